FILE: src/gmo_pkg.sv
package gmo_pkg;

   localparam int MaxWidth    = 1024;
   localparam int MaxHeight   = 4096;
   localparam int ColW        = $clog2(MaxWidth);
   localparam int RowW        = $clog2(MaxHeight);
   localparam int WidthRegW   = 11;
   localparam int HeightRegW  = 13;
   localparam int CsrDataW    = 13;
   localparam int PixW        = 8;
   localparam int DiffW       = PixW + 1;
   localparam int MagW        = 13;
   localparam int AngW        = 16;
   localparam int CordicSteps = 21;
   localparam int StepW       = 5;
   localparam int SqrtSteps   = 13;
   localparam int PrecShift   = 20;
   localparam int CordW       = 32;
   localparam int ZW          = 33;

   localparam logic CsrImageWidth  = 1'b0;
   localparam logic CsrImageHeight = 1'b1;

   localparam logic [AngW-1:0] AngZero         = 16'd0;
   localparam logic [AngW-1:0] AngQuarterTurn  = 16'd16384;
   localparam logic [AngW-1:0] AngHalfTurn     = 16'd32768;
   localparam logic [AngW-1:0] AngThreeQuarter = 16'd49152;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_ITER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             calc;
      logic             iter;
      logic [StepW-1:0] step;
      logic             load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic has_result;
   } dp_status_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [CordW-1:0] atan_turn(input logic [StepW-1:0] i);
      logic [CordW-1:0] v;
      case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/gmo_req_if.sv
interface gmo_req_if;
   logic                      valid;
   logic                      ready;
   logic [gmo_pkg::PixW-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

FILE: src/gmo_rsp_if.sv
interface gmo_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gmo_pkg::MagW-1:0]  magnitude;
   logic [gmo_pkg::AngW-1:0]  angle;
   logic [gmo_pkg::RowW-1:0]  center_row;
   logic [gmo_pkg::ColW-1:0]  center_col;
   logic                      frame_last;

   modport source (output valid, output magnitude, output angle, output center_row,
                   output center_col, output frame_last, input ready);
   modport sink (input valid, input magnitude, input angle, input center_row,
                 input center_col, input frame_last, output ready);
endinterface

FILE: src/gradient_magnitude_orientation.sv
// Gradient magnitude and orientation by central differences on a raster pixel stream.
// req_ch carries one 8-bit gray pixel per transaction in raster order; rsp_ch carries
// one result per interior pixel (border pixels give none): magnitude with 4 fraction
// bits, angle in 1/65536 turn, the pixel's row and column, and frame_last on the final
// interior pixel. csr_write_en/csr_index/csr_data set image width (index 0) and image
// height (index 1); the user must write these only while idle, which is not enforced.
// Pixels are taken one at a time. A border pixel occupies the block for the line store
// read and then the window update. An interior pixel then runs the steps of the shared
// square root and rotation unit and loads the output register once that register is
// free, and only after the load is the next pixel taken.
// The output register holds a result while the receiver stalls; the next pixel is
// still taken and processed, and only the load of the following result waits.
// Reset (synchronous, active high) clears the counters, the window and the
// handshake; registers return to 1024 x 1024. Line stores are not cleared.
module gradient_magnitude_orientation (
   input  logic                         clock,
   input  logic                         reset,
   gmo_req_if.sink                      req_ch,
   gmo_rsp_if.source                    rsp_ch,
   input  logic                         csr_write_en,
   input  logic                         csr_index,
   input  logic [gmo_pkg::CsrDataW-1:0] csr_data
);
   gmo_pkg::ctrl_cmd_type  cmd;
   gmo_pkg::dp_status_type status;

   gmo_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gmo_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .pixel        (req_ch.pixel),
      .cmd          (cmd),
      .status       (status),
      .magnitude    (rsp_ch.magnitude),
      .angle        (rsp_ch.angle),
      .center_row   (rsp_ch.center_row),
      .center_col   (rsp_ch.center_col),
      .frame_last   (rsp_ch.frame_last)
   );

endmodule

FILE: src/gmo_datapath.sv
module gmo_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [gmo_pkg::CsrDataW-1:0]   csr_data,
   input  logic [gmo_pkg::PixW-1:0]       pixel,
   input  gmo_pkg::ctrl_cmd_type          cmd,
   output gmo_pkg::dp_status_type         status,
   output logic [gmo_pkg::MagW-1:0]       magnitude,
   output logic [gmo_pkg::AngW-1:0]       angle,
   output logic [gmo_pkg::RowW-1:0]       center_row,
   output logic [gmo_pkg::ColW-1:0]       center_col,
   output logic                           frame_last
);
   localparam int PW = gmo_pkg::PixW;
   localparam int DW = gmo_pkg::DiffW;
   localparam int CW = gmo_pkg::CordW;
   localparam int ZW = gmo_pkg::ZW;
   localparam logic [gmo_pkg::StepW-1:0] SqrtLen = gmo_pkg::StepW'(gmo_pkg::SqrtSteps);

   logic [gmo_pkg::WidthRegW-1:0]  width_ff;
   logic [gmo_pkg::HeightRegW-1:0] height_ff;
   logic [2*PW-1:0]                line_mem [gmo_pkg::MaxWidth];
   logic [2*PW-1:0]                rd_ff;
   logic [PW-1:0]                  px_ff;
   logic [PW-1:0]                  win0_ff, win1_ff, win2_ff, win3_ff;
   logic [gmo_pkg::RowW-1:0]       row_ff, row_in;
   logic [gmo_pkg::ColW-1:0]       col_ff, col_in;
   logic signed [DW-1:0]           a_ff, b_ff;
   logic [gmo_pkg::RowW-1:0]       mrow_ff;
   logic [gmo_pkg::ColW-1:0]       mcol_ff;
   logic                           mlast_ff;
   logic [25:0]                    n_ff;
   logic [15:0]                    rem_ff;
   logic [gmo_pkg::MagW-1:0]       root_ff;
   logic signed [CW-1:0]           x_ff, y_ff;
   logic signed [ZW-1:0]           z_ff;
   logic [gmo_pkg::MagW-1:0]       mag_ff;
   logic [gmo_pkg::AngW-1:0]       ang_ff;
   logic [gmo_pkg::RowW-1:0]       orow_ff;
   logic [gmo_pkg::ColW-1:0]       ocol_ff;
   logic                           olast_ff;

   logic [gmo_pkg::WidthRegW-1:0]  w_eff, wm1;
   logic [gmo_pkg::HeightRegW-1:0] h_eff, hm1;
   logic                           row_end, frame_end;
   logic [PW-1:0]                  up, up2;
   logic signed [DW-1:0]           a_c, b_c;
   logic [DW-1:0]                  a_abs, b_abs;
   logic [16:0]                    sq_sum;
   logic [15:0]                    rem_t;
   logic [14:0]                    trial;
   logic signed [CW-1:0]           xs, ys;
   logic signed [ZW-1:0]           dz;
   logic [gmo_pkg::MagW-1:0]       mag_c;
   logic [30:0]                    zc;
   logic [33:0]                    t, t_r;
   logic [gmo_pkg::AngW-1:0]       ang_c;

   // effective dimensions, clamped to the supported range
   always_comb begin
      if (width_ff < 11'd3) begin
         w_eff = 11'd3;
      end else if (width_ff > 11'(gmo_pkg::MaxWidth)) begin
         w_eff = 11'(gmo_pkg::MaxWidth);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < 13'd3) begin
         h_eff = 13'd3;
      end else if (height_ff > 13'(gmo_pkg::MaxHeight)) begin
         h_eff = 13'(gmo_pkg::MaxHeight);
      end else begin
         h_eff = height_ff;
      end
      wm1       = w_eff - 11'd1;
      hm1       = h_eff - 13'd1;
      row_end   = {1'b0, col_ff} >= wm1;
      frame_end = row_end && ({1'b0, row_ff} >= hm1);
      col_in    = row_end ? '0 : col_ff + 1'b1;
      row_in    = row_end ? (frame_end ? '0 : row_ff + 1'b1) : row_ff;
   end

   assign status.has_result = (row_ff >= 12'd2) && (col_ff >= 10'd2);

   always_comb begin
      up     = rd_ff[PW-1:0];
      up2    = rd_ff[2*PW-1:PW];
      a_c    = $signed({1'b0, win3_ff}) - $signed({1'b0, win2_ff});
      b_c    = $signed({1'b0, win1_ff}) - $signed({1'b0, up});
      a_abs  = a_c[DW-1] ? DW'(-a_c) : DW'(a_c);
      b_abs  = b_c[DW-1] ? DW'(-b_c) : DW'(b_c);
      sq_sum = 17'(a_abs * a_abs) + 17'(b_abs * b_abs);
   end

   // one rotation per step, and one square root digit per step while step < SqrtLen
   always_comb begin
      rem_t = {rem_ff[13:0], n_ff[25:24]};
      trial = {root_ff[11:0], 2'b01};
      xs    = x_ff >>> cmd.step;
      ys    = y_ff >>> cmd.step;
      dz    = $signed({1'b0, gmo_pkg::atan_turn(cmd.step)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1024;
         row_ff    <= '0;
         col_ff    <= '0;
         win0_ff   <= '0;
         win1_ff   <= '0;
         win2_ff   <= '0;
         win3_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               gmo_pkg::CsrImageWidth:  width_ff  <= csr_data[gmo_pkg::WidthRegW-1:0];
               gmo_pkg::CsrImageHeight: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.calc) begin
            win1_ff <= win0_ff;
            win0_ff <= up;
            win2_ff <= up2;
            win3_ff <= px_ff;
            row_ff  <= row_in;
            col_ff  <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= line_mem[col_ff];
         px_ff <= pixel;
      end
      if (cmd.calc) begin
         line_mem[col_ff] <= {up, px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         a_ff     <= a_c;
         b_ff     <= b_c;
         mrow_ff  <= row_ff - 1'b1;
         mcol_ff  <= col_ff - 1'b1;
         mlast_ff <= frame_end;
         n_ff     <= {1'b0, sq_sum, 8'd0};
         rem_ff   <= '0;
         root_ff  <= '0;
         x_ff     <= $signed({{(CW-DW-gmo_pkg::PrecShift){1'b0}}, a_abs,
                              {gmo_pkg::PrecShift{1'b0}}});
         y_ff     <= $signed({{(CW-DW-gmo_pkg::PrecShift){1'b0}}, b_abs,
                              {gmo_pkg::PrecShift{1'b0}}});
         z_ff     <= '0;
      end else if (cmd.iter) begin
         if (cmd.step < SqrtLen) begin
            n_ff <= {n_ff[23:0], 2'b00};
            if (rem_t >= {1'b0, trial}) begin
               rem_ff  <= rem_t - {1'b0, trial};
               root_ff <= {root_ff[11:0], 1'b1};
            end else begin
               rem_ff  <= rem_t;
               root_ff <= {root_ff[11:0], 1'b0};
            end
         end
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + dz;
         end else if (y_ff < 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - dz;
         end
      end
   end

   // rounding and quadrant mapping
   always_comb begin
      mag_c = root_ff + gmo_pkg::MagW'({16'd0, rem_ff} > {19'd0, root_ff});
      if (z_ff < 0) begin
         zc = '0;
      end else if (z_ff > $signed(33'h0_4000_0000)) begin
         zc = 31'h4000_0000;
      end else begin
         zc = z_ff[30:0];
      end
      if (!a_ff[DW-1] && !b_ff[DW-1]) begin
         t = {3'b0, zc};
      end else if (a_ff[DW-1] && !b_ff[DW-1]) begin
         t = (34'd1 << 31) - {3'b0, zc};
      end else if (a_ff[DW-1]) begin
         t = (34'd1 << 31) + {3'b0, zc};
      end else begin
         t = (34'd1 << 32) - {3'b0, zc};
      end
      t_r = t + 34'd32768;
      if (a_ff == 0) begin
         ang_c = b_ff[DW-1] ? gmo_pkg::AngThreeQuarter : gmo_pkg::AngQuarterTurn;
      end else if (b_ff == 0) begin
         ang_c = a_ff[DW-1] ? gmo_pkg::AngHalfTurn : gmo_pkg::AngZero;
      end else begin
         ang_c = t_r[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mag_ff   <= mag_c;
         ang_ff   <= ang_c;
         orow_ff  <= mrow_ff;
         ocol_ff  <= mcol_ff;
         olast_ff <= mlast_ff;
      end
   end

   assign magnitude  = mag_ff;
   assign angle      = ang_ff;
   assign center_row = orow_ff;
   assign center_col = ocol_ff;
   assign frame_last = olast_ff;

endmodule

FILE: src/gmo_controller.sv
module gmo_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  gmo_pkg::dp_status_type status,
   output gmo_pkg::ctrl_cmd_type  cmd
);
   localparam logic [gmo_pkg::StepW-1:0] LastStep = gmo_pkg::StepW'(gmo_pkg::CordicSteps - 1);

   gmo_pkg::state_type           state_ff, state_in;
   logic [gmo_pkg::StepW-1:0]    step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gmo_pkg::ST_IDLE: begin
            if (req_valid) state_in = gmo_pkg::ST_CALC;
         end
         gmo_pkg::ST_CALC: begin
            state_in = status.has_result ? gmo_pkg::ST_ITER : gmo_pkg::ST_IDLE;
         end
         gmo_pkg::ST_ITER: begin
            if (step_ff == LastStep) state_in = gmo_pkg::ST_DONE;
         end
         gmo_pkg::ST_DONE: begin
            if (out_free) state_in = gmo_pkg::ST_IDLE;
         end
         default: state_in = gmo_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step     = step_ff;
      step_in      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         gmo_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         gmo_pkg::ST_CALC: begin
            cmd.calc = 1'b1;
         end
         gmo_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
            step_in  = step_ff + 1'b1;
         end
         gmo_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gmo_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == gmo_pkg::ST_CALC)
      else $error("accepted pixel not followed by calc");

   a_iter_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gmo_pkg::ST_ITER && step_ff == LastStep) |=> state_ff == gmo_pkg::ST_DONE)
      else $error("iteration did not end after last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

FILE: tb/sv/tb_gradient_magnitude_orientation.sv
`timescale 1ns / 1ps

module tb_gradient_magnitude_orientation;

   localparam int CycleLimit = 4000000;
   localparam int DrainCycles = 40;

   typedef struct {
      logic [gmo_pkg::MagW-1:0] magnitude;
      logic [gmo_pkg::AngW-1:0] angle;
      logic [gmo_pkg::RowW-1:0] center_row;
      logic [gmo_pkg::ColW-1:0] center_col;
      logic                     frame_last;
   } gradient_result_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_index;
   logic [gmo_pkg::CsrDataW-1:0] csr_data;

   gmo_req_if req_ch();
   gmo_rsp_if rsp_ch();

   gradient_magnitude_orientation uut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // predictor state
   logic [gmo_pkg::WidthRegW-1:0]  width_reg;
   logic [gmo_pkg::HeightRegW-1:0] height_reg;
   logic [gmo_pkg::PixW-1:0] line_above [gmo_pkg::MaxWidth];
   logic [gmo_pkg::PixW-1:0] line_two_above [gmo_pkg::MaxWidth];
   logic [gmo_pkg::PixW-1:0] window [4];
   int unsigned row_pos;
   int unsigned col_pos;

   gradient_result_type pending_results[$];
   int errors;
   int pixels_sent;
   int results_seen;
   int frames_sent;
   longint cycles;
   bit steady;

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned rounded_sqrt(int unsigned n);
      int unsigned r;
      int unsigned bitv;
      int unsigned rem;
      r = 0;
      bitv = 32'd1 << 30;
      rem = n;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem = rem - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > r) r++;
      return r;
   endfunction

   function automatic longint atan_step(int i);
      longint tbl [gmo_pkg::CordicSteps] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652};
      return tbl[i];
   endfunction

   // first quadrant angle of (x0, y0) in 2^-32 turn
   function automatic longint quadrant_angle(longint x0, longint y0);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = x0 <<< gmo_pkg::PrecShift;
      y = y0 <<< gmo_pkg::PrecShift;
      z = 0;
      for (int i = 0; i < gmo_pkg::CordicSteps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_step(i);
         end else if (y < 0) begin
            x = x - ys; y = y + xs; z = z - atan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30)) z = longint'(1) << 30;
      return z;
   endfunction

   function automatic logic [gmo_pkg::AngW-1:0] gradient_angle(int a, int b);
      longint phi;
      longint t;
      if (a == 0) return (b < 0) ? gmo_pkg::AngThreeQuarter : gmo_pkg::AngQuarterTurn;
      if (b == 0) return (a > 0) ? gmo_pkg::AngZero : gmo_pkg::AngHalfTurn;
      phi = quadrant_angle((a < 0) ? -a : a, (b < 0) ? -b : b);
      if (a > 0 && b > 0) t = phi;
      else if (a < 0 && b > 0) t = (longint'(1) << 31) - phi;
      else if (a < 0) t = (longint'(1) << 31) + phi;
      else t = (longint'(1) << 32) - phi;
      return gmo_pkg::AngW'((t + 32768) >> 16);
   endfunction

   task automatic predict_pixel(logic [gmo_pkg::PixW-1:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      logic [gmo_pkg::PixW-1:0] up;
      logic [gmo_pkg::PixW-1:0] up2;
      bit row_end;
      bit frame_end;
      int a;
      int b;
      gradient_result_type res;
      w = clamp_dim(width_reg, gmo_pkg::MaxWidth);
      h = clamp_dim(height_reg, gmo_pkg::MaxHeight);
      r = row_pos;
      c = col_pos;
      row_end = c >= w - 1;
      frame_end = row_end && r >= h - 1;
      up = line_above[c];
      up2 = line_two_above[c];
      if (r >= 2 && c >= 2) begin
         a = int'(window[3]) - int'(window[2]);
         b = int'(window[1]) - int'(up);
         res.magnitude = gmo_pkg::MagW'(rounded_sqrt(32'(a * a + b * b) * 256));
         res.angle = gradient_angle(a, b);
         res.center_row = gmo_pkg::RowW'(r - 1);
         res.center_col = gmo_pkg::ColW'(c - 1);
         res.frame_last = frame_end;
         pending_results.insert(pending_results.size(), res);
      end
      window[1] = window[0];
      window[0] = up;
      window[2] = up2;
      window[3] = px;
      line_two_above[c] = up;
      line_above[c] = px;
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : r + 1;
         if (frame_end) frames_sent++;
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic send_pixel(logic [gmo_pkg::PixW-1:0] px);
      while (!steady && $urandom_range(99) < 29) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_pixel(px);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= gmo_pkg::CsrDataW'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == gmo_pkg::CsrImageWidth) width_reg = gmo_pkg::WidthRegW'(value);
      else height_reg = gmo_pkg::HeightRegW'(value);
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      wait_idle();
      write_csr(gmo_pkg::CsrImageWidth, w);
      write_csr(gmo_pkg::CsrImageHeight, h);
   endtask

   function automatic logic [gmo_pkg::PixW-1:0] random_pixel();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 8'hFF : 8'h00;
         default: return gmo_pkg::PixW'($urandom);
      endcase
   endfunction

   // sends the rest of the current frame with random pixels
   task automatic random_frame();
      int start;
      start = frames_sent;
      while (frames_sent == start) send_pixel(random_pixel());
   endtask

   // 3x3 frame whose single interior result depends on four neighbors
   task automatic cross_frame(logic [7:0] top, logic [7:0] left, logic [7:0] right,
                              logic [7:0] bottom);
      send_pixel(8'h00); send_pixel(top);    send_pixel(8'h00);
      send_pixel(left);  send_pixel(8'h5A);  send_pixel(right);
      send_pixel(8'h00); send_pixel(bottom); send_pixel(8'h00);
   endtask

   task automatic test_special_angles();
      set_size(3, 3);
      cross_frame(8'd0, 8'd0, 8'd0, 8'd0);          // both differences zero
      cross_frame(8'd0, 8'd255, 8'd0, 8'd0);        // a zero, b positive
      cross_frame(8'd7, 8'd0, 8'd200, 8'd7);        // a zero, b negative
      cross_frame(8'd255, 8'd3, 8'd3, 8'd0);        // b zero, a negative
      cross_frame(8'd0, 8'd0, 8'd255, 8'd255);      // largest magnitude
   endtask

   task automatic test_register_clamps();
      set_size(0, 1);
      random_frame();
      set_size(2, 2);
      random_frame();
      // oversized width: the first row ends at the largest width, later rows are narrow
      set_size(2047, 3);
      repeat (gmo_pkg::MaxWidth) send_pixel(random_pixel());
      set_size(5, 3);
      random_frame();
   endtask

   // shrink the row length part way through a frame
   task automatic test_resize_in_frame();
      set_size(10, 6);
      repeat (27) send_pixel(random_pixel());
      set_size(5, 5);
      random_frame();
      set_size(7, 4);
      random_frame();
   endtask

   task automatic test_random_frames();
      int target;
      target = pixels_sent + 300;
      while (pixels_sent < target) begin
         if ($urandom_range(9) == 0) set_size($urandom_range(13, 40), $urandom_range(3, 6));
         else set_size($urandom_range(3, 12), $urandom_range(3, 8));
         steady = ($urandom_range(7) == 0);
         random_frame();
         steady = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= 29);
      end
   end

   always @(posedge clock) begin
      gradient_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.magnitude !== want.magnitude) begin
               $error("magnitude expected %0d actual %0d", want.magnitude, rsp_ch.magnitude);
               errors++;
            end
            if (rsp_ch.angle !== want.angle) begin
               $error("angle expected %0d actual %0d", want.angle, rsp_ch.angle);
               errors++;
            end
            if (rsp_ch.center_row !== want.center_row) begin
               $error("center_row expected %0d actual %0d", want.center_row,
                      rsp_ch.center_row);
               errors++;
            end
            if (rsp_ch.center_col !== want.center_col) begin
               $error("center_col expected %0d actual %0d", want.center_col,
                      rsp_ch.center_col);
               errors++;
            end
            if (rsp_ch.frame_last !== want.frame_last) begin
               $error("frame_last expected %0d actual %0d", want.frame_last,
                      rsp_ch.frame_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      cycles = 0;
      errors = 0;
      pixels_sent = 0;
      results_seen = 0;
      frames_sent = 0;
      steady = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = gmo_pkg::CsrImageWidth;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      rsp_ch.ready = 1'b0;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      for (int i = 0; i < gmo_pkg::MaxWidth; i++) begin
         line_above[i] = '0;
         line_two_above[i] = '0;
      end
      for (int i = 0; i < 4; i++) window[i] = '0;
      row_pos = 0;
      col_pos = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_angles();
      test_resize_in_frame();
      test_random_frames();
      test_register_clamps();
      wait_idle();

      $display("sent %0d pixels in %0d frames, checked %0d gradient results",
               pixels_sent, frames_sent, results_seen);
      $display("covered special angles, register clamping, in-frame resize, random stalls");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
